FILE: hdl/qte_pkg.sv
// Shared widths, limits and the arctangent table for the quaternion to Euler block.
// No dependencies; every other file of the block refers to this package.
package qte_pkg;

   // component after load: signed Q1.24
   localparam int QW = 25;
   localparam int FRAC = 24;
   // exact products and doubled sums at 48 fraction bits
   localparam int PW = 2 * QW;
   localparam int SW = PW + 2;
   // terms at 30 fraction bits
   localparam int TW = 34;
   localparam int T2W = 32;
   localparam int TSHIFT = 18;
   // square root radicand, partial result and root
   localparam int RADW = 61;
   localparam int RESW = 62;
   localparam int ROOTW = 31;
   localparam int SQ_STEPS = 31;
   // CORDIC datapath and angle accumulator (24 fraction bits)
   localparam int CXW = 37;
   localparam int AW = 28;
   localparam int TAB_LEN = 24;
   // output angles, 13 fraction bits: roll and yaw Q3.13, pitch Q2.13
   localparam int ROLL_W = 16;
   localparam int PITCH_W = 15;
   localparam int ROLL_LIM = 25736;
   localparam int PITCH_LIM = 12868;

   localparam logic signed [AW-1:0] PI_Q24 = 28'sd52707179;
   localparam logic signed [SW-1:0] ONE_Q48 = 52'sd1 <<< 48;
   localparam logic signed [TW-1:0] ONE_Q30 = 34'sd1 <<< 30;
   localparam logic [RADW-1:0] ONE_Q60 = 61'd1 << 60;

   localparam logic signed [AW-1:0] ATAN_TAB [TAB_LEN] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
      28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069,
      28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
      28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
      28'sd256, 28'sd128, 28'sd64, 28'sd32,
      28'sd16, 28'sd8, 28'sd4, 28'sd2
   };

   // atan2 operands that travel alongside the square root
   typedef struct packed {
      logic signed [TW-1:0]  t0;
      logic signed [TW-1:0]  t1;
      logic signed [T2W-1:0] t2;
      logic signed [TW-1:0]  t3;
      logic signed [TW-1:0]  t4;
   } terms_type;

endpackage

FILE: hdl/qte_if.sv
// Valid/ready channel interfaces: quaternion beats in, Euler angle beats out.
// Depends on qte_pkg for the output widths.
interface qte_req_if #(parameter int WIDTH = 16);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] quat_x;
   logic signed [WIDTH-1:0] quat_y;
   logic signed [WIDTH-1:0] quat_z;
   logic signed [WIDTH-1:0] quat_w;

   modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [qte_pkg::ROLL_W-1:0]  roll;
   logic signed [qte_pkg::PITCH_W-1:0] pitch;
   logic signed [qte_pkg::ROLL_W-1:0]  yaw;

   modport source (output valid, roll, pitch, yaw, input ready);
   modport sink (input valid, roll, pitch, yaw, output ready);
endinterface

FILE: hdl/qte_front.sv
// Front end: load components, form the five atan2 terms, square and subtract for sqrt.
// Five register stages; depends on qte_pkg.
module qte_front #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 valid_in,
   input  logic signed [COMPONENT_WIDTH-1:0]    quat_x,
   input  logic signed [COMPONENT_WIDTH-1:0]    quat_y,
   input  logic signed [COMPONENT_WIDTH-1:0]    quat_z,
   input  logic signed [COMPONENT_WIDTH-1:0]    quat_w,
   output logic                                 valid_out,
   output qte_pkg::terms_type                   terms,
   output logic [qte_pkg::RADW-1:0]             rad
);
   import qte_pkg::*;

   logic signed [QW-1:0] lx, ly, lz, lw;
   logic signed [QW-1:0] x_ff, y_ff, z_ff, w_ff;
   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // bring each component to 24 fraction bits
   generate
      if (COMPONENT_WIDTH - 1 <= FRAC) begin : g_widen
         localparam int LSH = FRAC - (COMPONENT_WIDTH - 1);
         assign lx = QW'(quat_x) <<< LSH;
         assign ly = QW'(quat_y) <<< LSH;
         assign lz = QW'(quat_z) <<< LSH;
         assign lw = QW'(quat_w) <<< LSH;
      end else begin : g_narrow
         localparam int RSH = (COMPONENT_WIDTH - 1) - FRAC;
         assign lx = QW'(quat_x >>> RSH);
         assign ly = QW'(quat_y >>> RSH);
         assign lz = QW'(quat_z >>> RSH);
         assign lw = QW'(quat_w >>> RSH);
      end
   endgenerate

   // stage 1: register loaded components
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= lx;
         y_ff <= ly;
         z_ff <= lz;
         w_ff <= lw;
      end
   end

   // stage 2: exact products
   logic signed [PW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= w_ff * x_ff;
         yz_ff <= y_ff * z_ff;
         xx_ff <= x_ff * x_ff;
         yy_ff <= y_ff * y_ff;
         wy_ff <= w_ff * y_ff;
         zx_ff <= z_ff * x_ff;
         wz_ff <= w_ff * z_ff;
         xy_ff <= x_ff * y_ff;
         zz_ff <= z_ff * z_ff;
      end
   end

   // stage 3: doubled sums, floor shift to 30 fraction bits, clamp the pitch term
   logic signed [SW-1:0] e_wx, e_yz, e_xx, e_yy, e_wy, e_zx, e_wz, e_xy, e_zz;
   logic signed [SW-1:0] s0, s1, s2, s3, s4;
   logic signed [TW-1:0] t2_raw;
   logic signed [T2W-1:0] t2_clamp;
   assign e_wx = SW'(wx_ff);
   assign e_yz = SW'(yz_ff);
   assign e_xx = SW'(xx_ff);
   assign e_yy = SW'(yy_ff);
   assign e_wy = SW'(wy_ff);
   assign e_zx = SW'(zx_ff);
   assign e_wz = SW'(wz_ff);
   assign e_xy = SW'(xy_ff);
   assign e_zz = SW'(zz_ff);
   assign s0 = (e_wx + e_yz) <<< 1;
   assign s1 = ONE_Q48 - ((e_xx + e_yy) <<< 1);
   assign s2 = (e_wy - e_zx) <<< 1;
   assign s3 = (e_wz + e_xy) <<< 1;
   assign s4 = ONE_Q48 - ((e_yy + e_zz) <<< 1);
   assign t2_raw = TW'(s2 >>> TSHIFT);

   always_comb begin
      if (t2_raw > ONE_Q30) begin
         t2_clamp = T2W'(ONE_Q30);
      end else if (t2_raw < -ONE_Q30) begin
         t2_clamp = T2W'(-ONE_Q30);
      end else begin
         t2_clamp = T2W'(t2_raw);
      end
   end

   terms_type t3_ff, t4_ff, t5_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         t3_ff.t0 <= TW'(s0 >>> TSHIFT);
         t3_ff.t1 <= TW'(s1 >>> TSHIFT);
         t3_ff.t2 <= t2_clamp;
         t3_ff.t3 <= TW'(s3 >>> TSHIFT);
         t3_ff.t4 <= TW'(s4 >>> TSHIFT);
      end
   end

   // stage 4: square the clamped pitch term
   logic signed [2*T2W-1:0] sq_full;
   logic [RADW-1:0]         sq_ff, rad_ff;
   assign sq_full = t3_ff.t2 * t3_ff.t2;
   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_full[RADW-1:0];
         t4_ff <= t3_ff;
      end
   end

   // stage 5: radicand 1 - t^2 at 60 fraction bits
   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff <= ONE_Q60 - sq_ff;
         t5_ff  <= t4_ff;
      end
   end

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   assign valid_out = v5_ff;
   assign terms     = t5_ff;
   assign rad       = rad_ff;

endmodule

FILE: hdl/qte_isqrt.sv
// Pipelined floor square root, one result bit per stage, carrying the atan2 terms.
// Depends on qte_pkg.
module qte_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          valid_in,
   input  logic [qte_pkg::RADW-1:0]      rad,
   input  qte_pkg::terms_type            terms_in,
   output logic                          valid_out,
   output logic [qte_pkg::ROOTW-1:0]     root,
   output qte_pkg::terms_type            terms_out
);
   import qte_pkg::*;

   logic [RADW-1:0] rem_ff [SQ_STEPS];
   logic [RESW-1:0] res_ff [SQ_STEPS];
   terms_type       side_ff [SQ_STEPS];
   logic            v_ff [SQ_STEPS];

   genvar k;
   generate
      for (k = 0; k < SQ_STEPS; k++) begin : g_step
         localparam logic [RESW-1:0] BITV = RESW'(1) << (2 * (SQ_STEPS - 1 - k));
         logic [RADW-1:0] rem_p;
         logic [RESW-1:0] res_p, trial;
         terms_type       side_p;
         logic            v_p;
         logic            fits;

         if (k == 0) begin : g_first
            assign rem_p  = rad;
            assign res_p  = '0;
            assign side_p = terms_in;
            assign v_p    = valid_in;
         end else begin : g_next
            assign rem_p  = rem_ff[k-1];
            assign res_p  = res_ff[k-1];
            assign side_p = side_ff[k-1];
            assign v_p    = v_ff[k-1];
         end

         // try this root bit; keep it when the remainder covers it
         assign trial = res_p + BITV;
         assign fits  = RESW'(rem_p) >= trial;

         always_ff @(posedge clock) begin
            if (en) begin
               if (fits) begin
                  rem_ff[k] <= rem_p - RADW'(trial);
                  res_ff[k] <= (res_p >> 1) + BITV;
               end else begin
                  rem_ff[k] <= rem_p;
                  res_ff[k] <= res_p >> 1;
               end
               side_ff[k] <= side_p;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en) begin
               v_ff[k] <= v_p;
            end
         end
      end
   endgenerate

   assign valid_out = v_ff[SQ_STEPS-1];
   assign root      = res_ff[SQ_STEPS-1][ROOTW-1:0];
   assign terms_out = side_ff[SQ_STEPS-1];

endmodule

FILE: hdl/qte_cordic.sv
// Vectoring CORDIC atan2, one micro-rotation per stage, then round and saturate to 13 fraction bits (Q3.13 by default).
// Depends on qte_pkg for the datapath widths and the arctangent table.
module qte_cordic #(
   parameter int ITERATIONS = 16,
   parameter int LIM = 25736,
   parameter int OW = 16
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [qte_pkg::CXW-1:0]    y_in,
   input  logic signed [qte_pkg::CXW-1:0]    x_in,
   output logic signed [OW-1:0]              angle
);
   import qte_pkg::*;

   localparam int NE = (ITERATIONS > TAB_LEN) ? TAB_LEN : ITERATIONS;
   localparam int RW = AW - 10;

   logic signed [CXW-1:0] x_ff [NE+1];
   logic signed [CXW-1:0] y_ff [NE+1];
   logic signed [AW-1:0]  z_ff [NE+1];
   logic                  zero_ff [NE+1];

   // pre-rotate by pi when the vector points left; flag the null vector
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            x_ff[0] <= -x_in;
            y_ff[0] <= -y_in;
            z_ff[0] <= (y_in >= 0) ? PI_Q24 : -PI_Q24;
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            z_ff[0] <= '0;
         end
      end
   end

   // micro-rotations toward the x axis
   genvar i;
   generate
      for (i = 0; i < NE; i++) begin : g_rot
         logic signed [CXW-1:0] xs, ys;
         assign xs = x_ff[i] >>> i;
         assign ys = y_ff[i] >>> i;
         always_ff @(posedge clock) begin
            if (en) begin
               zero_ff[i+1] <= zero_ff[i];
               if (y_ff[i] >= 0) begin
                  x_ff[i+1] <= x_ff[i] + ys;
                  y_ff[i+1] <= y_ff[i] - xs;
                  z_ff[i+1] <= z_ff[i] + ATAN_TAB[i];
               end else begin
                  x_ff[i+1] <= x_ff[i] - ys;
                  y_ff[i+1] <= y_ff[i] + xs;
                  z_ff[i+1] <= z_ff[i] - ATAN_TAB[i];
               end
            end
         end
      end
   endgenerate

   // round half up to 13 fraction bits and saturate
   localparam logic signed [AW:0]   RND  = (AW+1)'(1024);
   localparam logic signed [RW-1:0] LIMV = RW'(LIM);
   logic signed [AW:0]   rsum;
   logic signed [RW-1:0] rq;
   logic signed [OW-1:0] ang_ff;
   assign rsum = (AW+1)'(z_ff[NE]) + RND;
   assign rq   = RW'(rsum >>> 11);

   always_ff @(posedge clock) begin
      if (en) begin
         if (zero_ff[NE]) begin
            ang_ff <= '0;
         end else if (rq > LIMV) begin
            ang_ff <= OW'(LIMV);
         end else if (rq < -LIMV) begin
            ang_ff <= OW'(-LIMV);
         end else begin
            ang_ff <= OW'(rq);
         end
      end
   end

   assign angle = ang_ff;

endmodule

FILE: hdl/quaternion_to_euler_angles.sv
// Quaternion to roll/pitch/yaw. Pipeline: 5 front stages + 31 square-root stages +
// min(CORDIC_ITERATIONS,24)+2 CORDIC stages + 1 output register.
// Throughput: one beat per cycle while skid is empty; sqrt and CORDIC set the depth.
// A skid register behind the output register keeps req ready registered.
// Reset clears all valid bits and the output handshake; payload registers are not reset.
module quaternion_to_euler_angles #(
   parameter int CORDIC_ITERATIONS = 16,
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic   clock,
   input  logic   reset,
   qte_req_if.sink    req_bus,
   qte_rsp_if.source  rsp_bus
);
   import qte_pkg::*;

   localparam int NE = (CORDIC_ITERATIONS > TAB_LEN) ? TAB_LEN : CORDIC_ITERATIONS;
   localparam int LC = NE + 2;

   logic en;
   logic skid_v_ff, out_v_ff;

   // whole pipeline advances while the skid register is empty
   assign en = !skid_v_ff;
   assign req_bus.ready = en;

   logic              front_v;
   terms_type         front_terms;
   logic [RADW-1:0]   front_rad;

   qte_front #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (req_bus.valid),
      .quat_x    (req_bus.quat_x),
      .quat_y    (req_bus.quat_y),
      .quat_z    (req_bus.quat_z),
      .quat_w    (req_bus.quat_w),
      .valid_out (front_v),
      .terms     (front_terms),
      .rad       (front_rad)
   );

   logic              sq_v;
   logic [ROOTW-1:0]  sq_root;
   terms_type         sq_terms;

   qte_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (front_v),
      .rad       (front_rad),
      .terms_in  (front_terms),
      .valid_out (sq_v),
      .root      (sq_root),
      .terms_out (sq_terms)
   );

   logic signed [CXW-1:0] roll_y, roll_x, pitch_y, pitch_x, yaw_y, yaw_x;
   assign roll_y  = CXW'(sq_terms.t0);
   assign roll_x  = CXW'(sq_terms.t1);
   assign pitch_y = CXW'(sq_terms.t2);
   assign pitch_x = CXW'({1'b0, sq_root});
   assign yaw_y   = CXW'(sq_terms.t3);
   assign yaw_x   = CXW'(sq_terms.t4);

   logic signed [ROLL_W-1:0]  roll_a, yaw_a;
   logic signed [PITCH_W-1:0] pitch_a;

   qte_cordic #(.ITERATIONS(CORDIC_ITERATIONS), .LIM(ROLL_LIM), .OW(ROLL_W)) u_roll (
      .clock (clock), .en (en), .y_in (roll_y), .x_in (roll_x), .angle (roll_a)
   );
   qte_cordic #(.ITERATIONS(CORDIC_ITERATIONS), .LIM(PITCH_LIM), .OW(PITCH_W)) u_pitch (
      .clock (clock), .en (en), .y_in (pitch_y), .x_in (pitch_x), .angle (pitch_a)
   );
   qte_cordic #(.ITERATIONS(CORDIC_ITERATIONS), .LIM(ROLL_LIM), .OW(ROLL_W)) u_yaw (
      .clock (clock), .en (en), .y_in (yaw_y), .x_in (yaw_x), .angle (yaw_a)
   );

   // carry valid through the CORDIC stages
   logic cv_ff [LC];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LC; j++) begin
            cv_ff[j] <= 1'b0;
         end
      end else if (en) begin
         cv_ff[0] <= sq_v;
         for (int j = 1; j < LC; j++) begin
            cv_ff[j] <= cv_ff[j-1];
         end
      end
   end

   logic pipe_v;
   logic take;
   assign pipe_v = en && cv_ff[LC-1];
   assign take   = out_v_ff && rsp_bus.ready;

   // output register and skid register payload
   logic signed [ROLL_W-1:0]  out_roll_ff, out_yaw_ff, skid_roll_ff, skid_yaw_ff;
   logic signed [PITCH_W-1:0] out_pitch_ff, skid_pitch_ff;

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_bus.ready) begin
            out_roll_ff  <= skid_roll_ff;
            out_pitch_ff <= skid_pitch_ff;
            out_yaw_ff   <= skid_yaw_ff;
         end
      end else if (pipe_v) begin
         if (!out_v_ff || rsp_bus.ready) begin
            out_roll_ff  <= roll_a;
            out_pitch_ff <= pitch_a;
            out_yaw_ff   <= yaw_a;
         end else begin
            skid_roll_ff  <= roll_a;
            skid_pitch_ff <= pitch_a;
            skid_yaw_ff   <= yaw_a;
         end
      end
   end

   // output and skid occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (take) begin
            out_v_ff <= skid_v_ff || pipe_v;
         end else if (!out_v_ff) begin
            out_v_ff <= pipe_v;
         end
         if (skid_v_ff) begin
            if (rsp_bus.ready) begin
               skid_v_ff <= 1'b0;
            end
         end else if (pipe_v && out_v_ff && !rsp_bus.ready) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   assign rsp_bus.valid = out_v_ff;
   assign rsp_bus.roll  = out_roll_ff;
   assign rsp_bus.pitch = out_pitch_ff;
   assign rsp_bus.yaw   = out_yaw_ff;

endmodule
